FILE: rtl/iflpm_pkg.sv
// iflpm_pkg: shared types, codes and checksum helpers for the ipv4 forwarding block
// used by iflpm_cell and ipv4_forward_lpm; no dependencies
`timescale 1ns / 1ps

package iflpm_pkg;

   localparam int ROUTE_ENTRIES_DEF = 64;
   localparam int ADDR_W            = 32;
   localparam int LEN_W             = 6;
   localparam int MAX_PREFIX        = 32;
   localparam int IHL_MIN           = 5;
   localparam int SUM_W             = 17;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_HDR   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ACT_LOCAL   = 2'd0,
      ACT_FORWARD = 2'd1,
      ACT_TTL_ERR = 2'd2,
      ACT_NOROUTE = 2'd3
   } action_type;

   // lookup token handed from cell to cell
   typedef struct packed {
      logic              vld;
      logic [ADDR_W-1:0] dest;
      logic [LEN_W-1:0]  best_len;
      logic [ADDR_W-1:0] hop;
   } query_type;

   // route write broadcast to all cells
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] dest;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] hop;
   } route_wr_type;

   // ones'-complement add of a 16-bit value with end-around carry
   function automatic logic [SUM_W-1:0] fold_add(input logic [SUM_W-1:0] acc,
                                                 input logic [15:0] v);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + {2'b00, v};
      return SUM_W'(s[SUM_W:16]) + SUM_W'(s[15:0]);
   endfunction

   function automatic logic [SUM_W-1:0] add_word(input logic [SUM_W-1:0] acc,
                                                 input logic [31:0] w);
      logic [SUM_W-1:0] t;
      t = fold_add(acc, w[31:16]);
      return fold_add(t, w[15:0]);
   endfunction

   // prefix length 0..32 to network mask
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      return ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

FILE: rtl/ipv4_forward_lpm.sv
// ipv4_forward_lpm: ipv4 header parser, ttl and checksum rewrite, longest-prefix route lookup
// depends on iflpm_pkg and iflpm_cell
`timescale 1ns / 1ps

// channel  dir   port group         contents
// req      in    req_t*             tuser: op; tdata: header_word, route_dest, prefix_len, hop
// rsp      out   rsp_t*             tuser: action; tdata: next_hop, new_word2
// csr      in    csr_p*             apb, local_address at byte address 0
//
// clear, add and each header word are taken while idle. after the last header word the
// decision is made in ST_DECIDE for ttl or local delivery; when the route lookup runs,
// the token walks the whole cell chain in ST_SEARCH and ST_DONE then writes the result.
// no new transaction is taken until the decision sits in the output register.
// synchronous active-high reset empties the route table and the header state.

module ipv4_forward_lpm #(
   parameter int ROUTE_ENTRIES = iflpm_pkg::ROUTE_ENTRIES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // op
   input  logic [103:0]  req_tdata,   // header_word, route_dest, route_prefix_len, route_next_hop
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [1:0]    rsp_tuser,   // action
   output logic [63:0]   rsp_tdata,   // next_hop, new_word2
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
   localparam int AW    = iflpm_pkg::ADDR_W;
   localparam int LW    = iflpm_pkg::LEN_W;
   localparam int SW    = iflpm_pkg::SUM_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECIDE = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      local_addr_ff, local_addr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [3:0]         widx_ff, widx_in;
   logic [3:0]         hwords_ff, hwords_in;
   logic [SW-1:0]      psum_ff, psum_in;
   logic [31:0]        word2_ff, word2_in;
   logic [AW-1:0]      dest_ff, dest_in;
   logic [LW-1:0]      best_len_ff, best_len_in;
   logic [AW-1:0]      best_hop_ff, best_hop_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [1:0]         rsp_act_ff, rsp_act_in;
   logic [AW-1:0]      rsp_hop_ff, rsp_hop_in;
   logic [31:0]        rsp_w2_ff, rsp_w2_in;

   iflpm_pkg::op_type       op;
   logic [31:0]             hdr_word;
   logic [LW-1:0]           add_len;
   iflpm_pkg::route_wr_type wr;
   iflpm_pkg::query_type    chain [0:ROUTE_ENTRIES];

   logic               req_acc, csr_wr, out_free, search_go;
   logic [3:0]         ihl, widx_nxt, hw_cur;
   logic [SW-1:0]      ps_base, ps_sum;
   logic [7:0]         ttl;
   logic [31:0]        base_w2;
   logic [SW-1:0]      fwd_sum;

   assign op       = iflpm_pkg::op_type'(req_tuser);
   assign hdr_word = req_tdata[31:0];
   assign add_len  = (req_tdata[69:64] > LW'(iflpm_pkg::MAX_PREFIX)) ?
                     LW'(iflpm_pkg::MAX_PREFIX) : req_tdata[69:64];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : local_addr_ff;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tdata  = {rsp_w2_ff, rsp_hop_ff};

   // lookup token entering the head of the chain
   assign chain[0] = {search_go, dest_ff, LW'(0), AW'(0)};

   // route writes and fill count
   always_comb begin
      wr.en    = req_acc && (op == iflpm_pkg::OP_ADD) &&
                 (count_ff != CNT_W'(ROUTE_ENTRIES));
      wr.dest  = req_tdata[63:32];
      wr.len   = add_len;
      wr.hop   = req_tdata[101:70];
      count_in = count_ff;
      if (req_acc && (op == iflpm_pkg::OP_CLEAR)) begin
         count_in = '0;
      end else if (wr.en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      local_addr_in = local_addr_ff;
      if (csr_wr && !csr_paddr[2]) begin
         local_addr_in = csr_pwdata;
      end
   end

   // header word parsing
   always_comb begin
      ihl      = hdr_word[27:24];
      hw_cur   = (widx_ff == 4'd0) ?
                 ((ihl < 4'(iflpm_pkg::IHL_MIN)) ? 4'(iflpm_pkg::IHL_MIN) : ihl) :
                 hwords_ff;
      ps_base  = (widx_ff == 4'd0) ? '0 : psum_ff;
      ps_sum   = iflpm_pkg::add_word(ps_base, hdr_word);
      widx_nxt = widx_ff + 4'd1;

      widx_in   = widx_ff;
      hwords_in = hwords_ff;
      psum_in   = psum_ff;
      word2_in  = word2_ff;
      dest_in   = dest_ff;
      if (req_acc && (op == iflpm_pkg::OP_HDR)) begin
         hwords_in = hw_cur;
         if (widx_ff == 4'd2) begin
            word2_in = hdr_word;
            psum_in  = ps_base;
         end else begin
            psum_in  = ps_sum;
         end
         if (widx_ff == 4'd4) begin
            dest_in = hdr_word;
         end
         widx_in = (widx_nxt < hw_cur) ? widx_nxt : 4'd0;
      end
   end

   // decision sequencing
   always_comb begin
      ttl       = word2_ff[31:24];
      base_w2   = {ttl - 8'd1, word2_ff[23:16], 16'h0000};
      fwd_sum   = iflpm_pkg::add_word(psum_ff, base_w2);

      state_in    = state_ff;
      best_len_in = best_len_ff;
      best_hop_in = best_hop_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_act_in  = rsp_act_ff;
      rsp_hop_in  = rsp_hop_ff;
      rsp_w2_in   = rsp_w2_ff;
      search_go   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (op == iflpm_pkg::OP_HDR) && !(widx_nxt < hw_cur)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if ((ttl == 8'd0) || (dest_ff == local_addr_ff)) begin
               if (out_free) begin
                  rsp_vld_in = 1'b1;
                  rsp_act_in = (ttl == 8'd0) ? iflpm_pkg::ACT_TTL_ERR :
                                               iflpm_pkg::ACT_LOCAL;
                  rsp_hop_in = '0;
                  rsp_w2_in  = '0;
                  state_in   = ST_IDLE;
               end
            end else begin
               search_go = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (chain[ROUTE_ENTRIES].vld) begin
               best_len_in = chain[ROUTE_ENTRIES].best_len;
               best_hop_in = chain[ROUTE_ENTRIES].hop;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               if (best_len_ff != '0) begin
                  rsp_act_in = iflpm_pkg::ACT_FORWARD;
                  rsp_hop_in = best_hop_ff;
                  rsp_w2_in  = base_w2 | {16'h0000, ~fwd_sum[15:0]};
               end else begin
                  rsp_act_in = iflpm_pkg::ACT_NOROUTE;
                  rsp_hop_in = '0;
                  rsp_w2_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < ROUTE_ENTRIES; gi++) begin : g_cell
         iflpm_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .wr          (wr),
            .route_count (count_ff),
            .q_in        (chain[gi]),
            .q_out       (chain[gi+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         local_addr_ff <= '0;
         count_ff      <= '0;
         widx_ff       <= '0;
         hwords_ff     <= '0;
         psum_ff       <= '0;
         word2_ff      <= '0;
         dest_ff       <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         local_addr_ff <= local_addr_in;
         count_ff      <= count_in;
         widx_ff       <= widx_in;
         hwords_ff     <= hwords_in;
         psum_ff       <= psum_in;
         word2_ff      <= word2_in;
         dest_ff       <= dest_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      best_len_ff <= best_len_in;
      best_hop_ff <= best_hop_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_hop_ff  <= rsp_hop_in;
      rsp_w2_ff   <= rsp_w2_in;
   end

endmodule

FILE: rtl/iflpm_cell.sv
// iflpm_cell: one route table entry plus one stage of the lookup chain
// depends on iflpm_pkg
`timescale 1ns / 1ps

module iflpm_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  iflpm_pkg::route_wr_type wr,
   input  logic [CNT_W-1:0]       route_count,
   input  iflpm_pkg::query_type   q_in,
   output iflpm_pkg::query_type   q_out
);

   logic [iflpm_pkg::ADDR_W-1:0] dest_ff;
   logic [iflpm_pkg::LEN_W-1:0]  len_ff;
   logic [iflpm_pkg::ADDR_W-1:0] hop_ff;
   logic                         vld_ff, vld_in;
   iflpm_pkg::query_type         q_ff, q_in_next;
   logic                         active, hit;

   assign active = CNT_W'(INDEX) < route_count;
   assign hit    = active && (len_ff > q_in.best_len) &&
                   ((q_in.dest & iflpm_pkg::prefix_mask(len_ff)) == dest_ff);

   always_comb begin
      q_in_next = q_in;
      if (hit) begin
         q_in_next.best_len = len_ff;
         q_in_next.hop      = hop_ff;
      end
      vld_in = q_in.vld;
   end

   // route entry written when the fill count points here
   always_ff @(posedge clock) begin
      if (wr.en && (route_count == CNT_W'(INDEX))) begin
         dest_ff <= wr.dest;
         len_ff  <= wr.len;
         hop_ff  <= wr.hop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in_next;
   end

   always_comb begin
      q_out     = q_ff;
      q_out.vld = vld_ff;
   end

endmodule

FILE: sim/lpm_decision_checker.sv
// lpm_decision_checker: forwarding decision predictor and response scoreboard
// watches the req, rsp and csr channels of ipv4_forward_lpm; depends on iflpm_pkg
`timescale 1ns / 1ps

module lpm_decision_checker #(
   parameter int         ROUTE_ENTRIES  = iflpm_pkg::ROUTE_ENTRIES_DEF,
   parameter logic [2:0] LOCAL_ADDR_REG = 3'd0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [103:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [1:0]   rsp_tuser,
   input  logic [63:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending_count,
   output int           decisions_checked,
   output int           forwards_seen
);

   typedef struct packed {
      iflpm_pkg::action_type act;
      logic [31:0]           hop;
      logic [31:0]           word2;
   } decision_type;

   decision_type expected_decisions [$];
   logic [31:0]  route_net [ROUTE_ENTRIES];
   logic [5:0]   route_len [ROUTE_ENTRIES];
   logic [31:0]  route_hop [ROUTE_ENTRIES];
   int           n_routes;
   int           hdr_pos;
   int           hdr_len;
   int unsigned  csum;
   logic [31:0]  ttl_word;
   logic [31:0]  dst_addr;
   logic [31:0]  local_addr;
   int           n_fail;
   int           n_checked;
   int           n_forward;

   // end-around carry after every 16-bit add
   function automatic int unsigned csum_add16(input int unsigned acc, input logic [15:0] v);
      int unsigned s;
      s = acc + v;
      return (s >> 16) + (s & 32'h0000_ffff);
   endfunction

   function automatic int unsigned csum_add32(input int unsigned acc, input logic [31:0] w);
      return csum_add16(csum_add16(acc, w[31:16]), w[15:0]);
   endfunction

   function automatic logic [31:0] net_mask(input logic [5:0] len);
      return (len == 6'd0) ? 32'h0 : ~(32'hffff_ffff >> len);
   endfunction

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         n_fail++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   task automatic predict_request(input iflpm_pkg::op_type op, input logic [103:0] d);
      decision_type dec;
      logic [31:0]  w;
      logic [31:0]  base;
      logic [31:0]  s;
      logic [5:0]   plen;
      logic [7:0]   ttl;
      int           best;
      w = d[31:0];
      case (op)
         iflpm_pkg::OP_CLEAR: n_routes = 0;
         iflpm_pkg::OP_ADD: begin
            if (n_routes < ROUTE_ENTRIES) begin
               plen = (d[69:64] > 6'd32) ? 6'd32 : d[69:64];
               route_net[n_routes] = d[63:32];
               route_len[n_routes] = plen;
               route_hop[n_routes] = d[101:70];
               n_routes++;
            end
         end
         iflpm_pkg::OP_HDR: begin
            if (hdr_pos == 0) begin
               hdr_len = (w[27:24] < 4'd5) ? 5 : int'(w[27:24]);
               csum = 0;
            end
            // word 2 is rebuilt later, so it stays out of the running sum
            if (hdr_pos == 2) ttl_word = w;
            else csum = csum_add32(csum, w);
            if (hdr_pos == 4) dst_addr = w;
            hdr_pos++;
            if (hdr_pos >= hdr_len) begin
               hdr_pos = 0;
               ttl = ttl_word[31:24];
               dec.act = iflpm_pkg::ACT_NOROUTE;
               dec.hop = 32'h0;
               dec.word2 = 32'h0;
               if (ttl == 8'd0) begin
                  dec.act = iflpm_pkg::ACT_TTL_ERR;
               end else if (dst_addr == local_addr) begin
                  dec.act = iflpm_pkg::ACT_LOCAL;
               end else begin
                  best = 0;
                  // strict compare keeps the earliest route among equal lengths
                  for (int i = 0; i < n_routes; i++) begin
                     if (route_len[i] > best &&
                         (dst_addr & net_mask(route_len[i])) == route_net[i]) begin
                        best = route_len[i];
                        dec.hop = route_hop[i];
                     end
                  end
                  if (best > 0) begin
                     base = {ttl - 8'd1, ttl_word[23:16], 16'h0};
                     s = csum_add32(csum, base);
                     dec.act = iflpm_pkg::ACT_FORWARD;
                     dec.word2 = {base[31:16], ~s[15:0]};
                  end
               end
               expected_decisions.insert(expected_decisions.size(), dec);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         n_routes = 0;
         hdr_pos = 0;
         hdr_len = 0;
         csum = 0;
         ttl_word = 32'h0;
         dst_addr = 32'h0;
         local_addr = 32'h0;
         n_fail = 0;
         n_checked = 0;
         n_forward = 0;
         expected_decisions.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == LOCAL_ADDR_REG) begin
            if (csr_pwrite) local_addr = csr_pwdata;
            else check_field("local_address readback", local_addr, csr_prdata);
         end
         if (req_tvalid && req_tready) begin
            predict_request(iflpm_pkg::op_type'(req_tuser), req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decisions.size() == 0) begin
               n_fail++;
               $display("%0t ns: decision with none expected, action %0d hop %h word2 %h",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
            end else begin
               want = expected_decisions.pop_front();
               check_field("action", 32'(want.act), 32'(rsp_tuser));
               check_field("next_hop", want.hop, rsp_tdata[31:0]);
               check_field("new_word2", want.word2, rsp_tdata[63:32]);
               n_checked++;
               if (want.act == iflpm_pkg::ACT_FORWARD) n_forward++;
            end
         end
      end
      fail_count <= n_fail;
      pending_count <= expected_decisions.size();
      decisions_checked <= n_checked;
      forwards_seen <= n_forward;
   end

endmodule

FILE: sim/tb_top.sv
// tb_top: stimulus and verdict for ipv4_forward_lpm
// depends on iflpm_pkg, ipv4_forward_lpm and lpm_decision_checker
`timescale 1ns / 1ps

module tb_top;

   localparam int         ROUTE_ENTRIES  = iflpm_pkg::ROUTE_ENTRIES_DEF;
   localparam int         DECIDE_LATENCY = ROUTE_ENTRIES + 3;
   localparam logic [2:0] REG_LOCAL_ADDR = 3'd0;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = iflpm_pkg::OP_NONE;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;
   logic [63:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = 3'd0;
   logic [31:0]  csr_pwdata = 32'h0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int fail_count;
   int pending_count;
   int decisions_checked;
   int forwards_seen;

   int          req_count = 0;
   bit          steady = 1'b0;
   bit          hold_rsp = 1'b0;
   logic [31:0] cur_local = 32'h0;
   logic [31:0] known_net [$];
   logic [5:0]  known_len [$];

   ipv4_forward_lpm #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_dut (.*);

   lpm_decision_checker #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES),
      .LOCAL_ADDR_REG(REG_LOCAL_ADDR)
   ) u_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int low;
      do @(posedge clock); while (reset);
      forever begin
         low = steady ? 0 : $urandom_range(0, 11);
         if (hold_rsp) begin
            low += 300;
            hold_rsp = 1'b0;
         end
         if (low > 0) begin
            rsp_tready <= 1'b0;
            repeat (low) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [103:0] pack_req(input logic [31:0] word, input logic [31:0] dest,
                                             input logic [5:0] len, input logic [31:0] hop);
      return {2'b00, hop, len, dest, word};
   endfunction

   function automatic logic [103:0] rand_req();
      return pack_req($urandom, $urandom, 6'($urandom), $urandom);
   endfunction

   task automatic send(input iflpm_pkg::op_type op, input logic [103:0] data);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      req_count++;
   endtask

   task automatic clear_routes();
      send(iflpm_pkg::OP_CLEAR, rand_req());
      known_net.delete();
      known_len.delete();
   endtask

   task automatic send_route(input logic [31:0] net, input logic [5:0] len,
                             input logic [31:0] hop);
      if (known_net.size() < ROUTE_ENTRIES) begin
         known_net.insert(known_net.size(), net);
         known_len.insert(known_len.size(), len);
      end
      send(iflpm_pkg::OP_ADD, pack_req($urandom, net, len, hop));
   endtask

   task automatic add_random_route();
      logic [5:0]  len;
      logic [31:0] net;
      case ($urandom_range(0, 9))
         0: len = 6'd0;
         1: len = 6'd32;
         2: len = 6'($urandom_range(33, 63));
         default: len = 6'($urandom_range(4, 30));
      endcase
      net = $urandom & ((len == 6'd0) ? 32'h0 : ~(32'hffff_ffff >> len));
      // now and then a route with host bits set, which can never match
      if ($urandom_range(0, 15) == 0) net = $urandom;
      send_route(net, len, $urandom);
   endtask

   task automatic send_packet(input logic [3:0] ihl, input logic [7:0] ttl,
                              input logic [31:0] dest, input bit meddle, input int clear_at);
      logic [31:0] w;
      int          words;
      words = (ihl < 4'd5) ? 5 : int'(ihl);
      for (int i = 0; i < words; i++) begin
         case (i)
            0: w = {4'($urandom), ihl, 24'($urandom)};
            2: w = {ttl, 24'($urandom)};
            4: w = dest;
            default: w = $urandom;
         endcase
         send(iflpm_pkg::OP_HDR, pack_req(w, $urandom, 6'($urandom), $urandom));
         if (i == clear_at) begin
            clear_routes();
         end else if (meddle && $urandom_range(0, 11) == 0) begin
            // table changes and stray ops in the middle of a header
            case ($urandom_range(0, 3))
               0: clear_routes();
               1: send(iflpm_pkg::OP_NONE, rand_req());
               default: add_random_route();
            endcase
         end
      end
   endtask

   task automatic random_packet(input bit meddle);
      logic [3:0]  ihl;
      logic [7:0]  ttl;
      logic [31:0] dest;
      logic [5:0]  len;
      int          k;
      int          idx;
      case ($urandom_range(0, 9))
         0: ihl = 4'($urandom_range(0, 4));
         1: ihl = 4'($urandom_range(8, 15));
         default: ihl = 4'($urandom_range(5, 7));
      endcase
      case ($urandom_range(0, 15))
         0: ttl = 8'd0;
         1: ttl = 8'd1;
         2: ttl = 8'hff;
         default: ttl = 8'($urandom);
      endcase
      k = $urandom_range(0, 9);
      if (k < 6 && known_net.size() > 0) begin
         // land inside a known network so lookups mostly hit
         idx = $urandom_range(0, known_net.size() - 1);
         len = known_len[idx];
         dest = known_net[idx] | ($urandom & (32'hffff_ffff >> len));
      end else if (k == 6) begin
         dest = cur_local;
      end else begin
         dest = $urandom;
      end
      send_packet(ihl, ttl, dest, meddle, -1);
   endtask

   task automatic random_traffic(input int upto);
      while (req_count < upto) begin
         if ($urandom_range(0, 14) == 0) steady = !steady;
         case ($urandom_range(0, 19))
            0: begin
               clear_routes();
               repeat ($urandom_range(3, 10)) add_random_route();
            end
            1: send(iflpm_pkg::OP_NONE, rand_req());
            2, 3, 4: add_random_route();
            default: random_packet(1'b1);
         endcase
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // a decision may still be in the lookup chain
      repeat (DECIDE_LATENCY + 8) @(posedge clock);
   endtask

   task automatic reconfigure(input logic [31:0] value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_LOCAL_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read back right after the write
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      cur_local = value;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_route(32'h0a00_0000, 6'd8, 32'hc0a8_0001);
      send_route(32'h0a01_0000, 6'd16, 32'hc0a8_0002);
      send_route(32'h0a01_0000, 6'd16, 32'hc0a8_0003);   // same length, loses to the one above
      send_route(32'h0000_0000, 6'd0, 32'hc0a8_0004);    // zero length never wins
      send_route(32'hffff_ffff, 6'd63, 32'hffff_fffe);   // clamps to a host route
      send(iflpm_pkg::OP_NONE, pack_req('1, '1, '1, '1));
      send_packet(4'd0, 8'd0, 32'h0, 1'b0, -1);           // ttl zero toward local address
      send_packet(4'd5, 8'd1, 32'h0a01_0203, 1'b0, -1);
      send_packet(4'd5, 8'd255, 32'hffff_ffff, 1'b0, -1);
      send_packet(4'd6, 8'd64, 32'h0a01_0203, 1'b0, 1);   // table wiped mid header

      reconfigure(32'hffff_ffff);
      random_traffic(200);

      // long output stall while the sender keeps pushing
      steady = 1'b1;
      hold_rsp = 1'b1;
      repeat (8) random_packet(1'b0);
      steady = 1'b0;

      reconfigure($urandom);
      clear_routes();
      repeat (ROUTE_ENTRIES + 6) add_random_route();
      random_traffic(420);

      reconfigure(32'h0);
      random_traffic(560);

      wait_drained();
      $display("covered %0d requests across three local address changes, including a full table",
               req_count);
      $display("checked %0d decisions, %0d of them forwarded", decisions_checked,
               forwards_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
